// ===== src/mbd_pkg.sv =====
// Shared types and constants of the multi-button debouncer.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package mbd_pkg;

    // Number of channels that are really debounced, from 1 to 3.
    localparam int NUM_CHANNELS = 3;
    // Channel slots that the ports always carry.
    localparam int CHAN_SLOTS   = 3;
    localparam int COUNT_W      = 8;
    localparam int CFG_IDX_W    = 2;

    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [CHAN_SLOTS-1:0] chan_mask_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    // Register indexes of the configuration port.
    localparam cfg_idx_t REG_SETTLE_LIMIT_0 = 2'd0;
    localparam cfg_idx_t REG_SETTLE_LIMIT_1 = 2'd1;
    localparam cfg_idx_t REG_SETTLE_LIMIT_2 = 2'd2;

    // Settle limits after reset.
    localparam count_t LIMIT_RESET_0 = 8'd20;
    localparam count_t LIMIT_RESET_1 = 8'd20;
    localparam count_t LIMIT_RESET_2 = 8'd2;

    // What one lane reports for one tick.
    typedef struct packed {
        logic rise;
        logic fall;
    } lane_evt_t;

endpackage

`default_nettype wire

// ===== src/mbd_lane.sv =====
// One debounce lane: level history, settle counter and pending flag of a channel.
// Depends on mbd_pkg for the counter type and the event struct.
`default_nettype none

module mbd_lane (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire logic            level,
    input  wire mbd_pkg::count_t limit,
    output mbd_pkg::lane_evt_t   evt
);

    logic            last_level_reg, last_level_next;
    logic            pending_reg, pending_next;
    mbd_pkg::count_t count_reg, count_next;

    always_comb begin
        last_level_next = level;
        pending_next    = pending_reg;
        count_next      = count_reg;
        evt.rise        = 1'b0;
        evt.fall        = 1'b0;
        if (level != last_level_reg) begin
            count_next   = '0;
            pending_next = 1'b1;
        end else if (count_reg < limit) begin
            count_next = count_reg + mbd_pkg::count_t'(1);
        end else if (pending_reg) begin
            // Stable long enough: report the settled level once.
            pending_next = 1'b0;
            count_next   = '0;
            evt.rise     = level;
            evt.fall     = ~level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg <= 1'b0;
            pending_reg    <= 1'b0;
            count_reg      <= '0;
        end else if (advance) begin
            last_level_reg <= last_level_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mbd_merge.sv =====
// Merging stage: packs the lane events into masks and holds them in the output register.
// Depends on mbd_pkg for the event struct and mask type.
`default_nettype none

module mbd_merge (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire mbd_pkg::lane_evt_t lane_evt [mbd_pkg::CHAN_SLOTS],
    output logic                    can_load,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mbd_pkg::chan_mask_t     m_rise_events,
    output mbd_pkg::chan_mask_t     m_fall_events
);

    logic                valid_reg;
    mbd_pkg::chan_mask_t rise_reg, rise_next;
    mbd_pkg::chan_mask_t fall_reg, fall_next;

    always_comb begin
        for (int k = 0; k < mbd_pkg::CHAN_SLOTS; k++) begin
            rise_next[k] = lane_evt[k].rise;
            fall_next[k] = lane_evt[k].fall;
        end
    end

    // A new tick may enter when no result is held or the held result leaves in the same cycle.
    assign can_load = ~valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rise_reg <= rise_next;
            fall_reg <= fall_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_rise_events = rise_reg;
    assign m_fall_events = fall_reg;

endmodule

`default_nettype wire

// ===== src/multi_button_debouncer.sv =====
// Top level of the multi-button debouncer: settle limit registers, lanes, merging stage.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
//
//   channel   ports                               transfer when
//   input     s_valid s_ready s_pin_levels        s_valid && s_ready
//   result    m_valid m_ready m_rise/fall_events  m_valid && m_ready
//   config    cfg_wr_en cfg_index cfg_data        cfg_wr_en
//
// One tick per cycle while s_ready is high; its result is in the output register in the cycle after the transfer.
// Each lane's level and counter compares and its increment are the only logic between the registers.
// Reset clears every lane and sets the settle limits to 20, 20 and 2.
// While a result waits and m_ready is low, s_ready is low and the lanes hold.
`default_nettype none

module multi_button_debouncer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mbd_pkg::chan_mask_t s_pin_levels,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mbd_pkg::chan_mask_t      m_rise_events,
    output mbd_pkg::chan_mask_t      m_fall_events,
    input  wire logic                cfg_wr_en,
    input  wire mbd_pkg::cfg_idx_t   cfg_index,
    input  wire mbd_pkg::count_t     cfg_data
);

    mbd_pkg::count_t    limit_reg [mbd_pkg::CHAN_SLOTS];
    mbd_pkg::lane_evt_t lane_evt  [mbd_pkg::CHAN_SLOTS];
    logic               can_load;
    logic               accept;

    assign s_ready = can_load;
    assign accept  = s_valid & can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg[0] <= mbd_pkg::LIMIT_RESET_0;
            limit_reg[1] <= mbd_pkg::LIMIT_RESET_1;
            limit_reg[2] <= mbd_pkg::LIMIT_RESET_2;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mbd_pkg::REG_SETTLE_LIMIT_0: limit_reg[0] <= cfg_data;
                mbd_pkg::REG_SETTLE_LIMIT_1: limit_reg[1] <= cfg_data;
                mbd_pkg::REG_SETTLE_LIMIT_2: limit_reg[2] <= cfg_data;
                default: begin
                    // Writes beyond the last register are dropped.
                end
            endcase
        end
    end

    for (genvar k = 0; k < mbd_pkg::CHAN_SLOTS; k++) begin : g_lane
        if (k < mbd_pkg::NUM_CHANNELS) begin : g_used
            mbd_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .advance (accept),
                .level   (s_pin_levels[k]),
                .limit   (limit_reg[k]),
                .evt     (lane_evt[k])
            );
        end else begin : g_unused
            assign lane_evt[k] = '0;
        end
    end

    mbd_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .lane_evt      (lane_evt),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rise_events (m_rise_events),
        .m_fall_events (m_fall_events)
    );

endmodule

`default_nettype wire
